// ===== rtl/core/mlps_pkg.sv =====
// Shared types and constants of the MIDI loop playback sequencer.
// Used by mlps_ctrl, mlps_dp and the top level; depends on nothing.
`default_nettype none

package mlps_pkg;

  // Store depth and derived widths.
  localparam int EVENT_DEPTH = 64;
  localparam int ADDR_W      = $clog2(EVENT_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;

  // Field widths.
  localparam int TIME_W   = 24;
  localparam int FRAC_W   = 16;
  localparam int POS_W    = TIME_W + FRAC_W;
  localparam int OFFSET_W = 13;
  localparam int CMD_W    = 3;
  localparam int CFG_IDX_W = 1;

  // MIDI status decoding for note-off events.
  localparam logic [7:0] STATUS_MASK     = 8'hF0;
  localparam logic [7:0] NOTE_OFF_STATUS = 8'h80;

  // Register reset values and indexes.
  localparam logic [TIME_W-1:0] TEMPO_RESET = 24'd65536;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPO_STEP  = 1'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_ADD   = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_code_t;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_PLAY     = 2'd1,
    MODE_STOPPING = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FINISH,
    ST_REJECT
  } ctrl_state_t;

  // One stored event.
  typedef struct packed {
    logic [TIME_W-1:0] time_f;
    logic [7:0]        status;
    logic [7:0]        data1;
    logic [7:0]        data2;
    logic [1:0]        size;
  } event_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic stop;
    logic add;
    logic clear;
    logic capture;
    logic rd_en;
    logic rd_next;
    logic step;
    logic take;
    logic out_pend;
    logic out_last;
    logic out_reject;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    mode_t mode;
    logic  rp_lt_count;
    logic  more;
    logic  due;
    logic  note_off;
    logic  full;
    logic  pend_valid;
    logic  out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/mlps_ctrl.sv =====
// Controller state machine of the MIDI loop playback sequencer.
// Depends on mlps_pkg; drives the command struct of mlps_dp.
`default_nettype none

module mlps_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mlps_pkg::CMD_W-1:0]        command,
  input  mlps_pkg::dp_sts_t                 sts,
  output mlps_pkg::dp_cmd_t                 cmd
);
  import mlps_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        accept;
  logic        want;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // An event is wanted when due in play mode, or when it is a note-off while stopping.
  assign want = (sts.mode == MODE_PLAY) ? sts.due : sts.note_off;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (command)
            CMD_TICK: begin
              cmd.capture = 1'b1;
              if (sts.mode == MODE_PLAY || sts.mode == MODE_STOPPING) begin
                if (sts.rp_lt_count) begin
                  cmd.rd_en  = 1'b1;
                  state_next = ST_EVAL;
                end else begin
                  state_next = ST_FINISH;
                end
              end
            end
            CMD_START: cmd.start = 1'b1;
            CMD_STOP:  cmd.stop  = 1'b1;
            CMD_ADD: begin
              if (sts.full) begin
                state_next = ST_REJECT;
              end else begin
                cmd.add = 1'b1;
              end
            end
            CMD_CLEAR: cmd.clear = (sts.mode == MODE_IDLE);
            default: ;
          endcase
        end
      end
      ST_EVAL: begin
        if (sts.mode == MODE_PLAY && !sts.due) begin
          state_next = ST_FINISH;
        end else if (!want || !sts.pend_valid || sts.out_free) begin
          // Move the earlier pending event out before holding this one.
          if (want) begin
            cmd.take     = 1'b1;
            cmd.out_pend = sts.pend_valid;
          end
          cmd.step = 1'b1;
          if (sts.more) begin
            cmd.rd_en   = 1'b1;
            cmd.rd_next = 1'b1;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (!sts.pend_valid || sts.out_free) begin
          cmd.out_pend = sts.pend_valid;
          cmd.out_last = 1'b1;
          cmd.finish   = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_REJECT: begin
        if (sts.out_free) begin
          cmd.out_reject = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/mlps_dp.sv =====
// Datapath of the MIDI loop playback sequencer: event store, play state,
// pending event and output register. Depends on mlps_pkg; driven by mlps_ctrl.
`default_nettype none

module mlps_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [mlps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mlps_pkg::TIME_W-1:0]         cfg_data,
  input  logic [mlps_pkg::OFFSET_W-1:0]       frame_offset,
  input  logic                                repeat_req,
  input  logic [mlps_pkg::TIME_W-1:0]         event_time,
  input  logic [7:0]                          event_status,
  input  logic [7:0]                          event_data1,
  input  logic [7:0]                          event_data2,
  input  logic [1:0]                          event_size,
  input  mlps_pkg::dp_cmd_t                   cmd,
  output mlps_pkg::dp_sts_t                   sts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                result_kind,
  output logic [mlps_pkg::OFFSET_W-1:0]       out_frame_offset,
  output logic [7:0]                          out_status,
  output logic [7:0]                          out_data1,
  output logic [7:0]                          out_data2,
  output logic [1:0]                          out_size,
  output logic                                last
);
  import mlps_pkg::*;

  event_t              mem [EVENT_DEPTH];
  event_t              rd_ev;
  event_t              pend_ev;
  logic                pend_valid;
  logic [TIME_W-1:0]   loop_length;
  logic [TIME_W-1:0]   tempo_step;
  logic [CNT_W-1:0]    event_count;
  logic [CNT_W-1:0]    read_pointer;
  logic [CNT_W-1:0]    rp_inc;
  logic [POS_W-1:0]    play_position;
  mode_t               play_mode;
  logic                loop_forever;
  logic [OFFSET_W-1:0] tick_offset;
  logic [ADDR_W-1:0]   rd_addr;
  logic [POS_W:0]      pos_sum;
  logic                wrap;
  event_t              masked_ev;
  logic                out_free;

  assign rp_inc  = read_pointer + CNT_W'(1);
  assign rd_addr = cmd.rd_next ? rp_inc[ADDR_W-1:0] : read_pointer[ADDR_W-1:0];

  // Position advance and wrap test against the current loop length.
  assign pos_sum = {1'b0, play_position} + {{(POS_W + 1 - TIME_W){1'b0}}, tempo_step};
  assign wrap    = pos_sum >= {1'b0, loop_length, {FRAC_W{1'b0}}};

  // Event store: append at the fill count, read at the read pointer or the entry after it.
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      mem[event_count[ADDR_W-1:0]] <= '{time_f: event_time, status: event_status,
                                        data1: event_data1, data2: event_data2,
                                        size: event_size};
    end
    if (cmd.rd_en) begin
      rd_ev <= mem[rd_addr];
    end
  end

  // Play state, registers and pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_length   <= '0;
      tempo_step    <= TEMPO_RESET;
      event_count   <= '0;
      read_pointer  <= '0;
      play_position <= '0;
      play_mode     <= MODE_IDLE;
      loop_forever  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_LOOP_LENGTH: loop_length <= cfg_data;
          REG_TEMPO_STEP:  tempo_step  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clear) begin
        loop_length   <= '0;
        play_position <= '0;
        read_pointer  <= '0;
        event_count   <= '0;
      end
      if (cmd.start) begin
        if (play_mode == MODE_PLAY) begin
          loop_forever <= repeat_req;
        end else if (play_mode == MODE_IDLE && loop_length != '0) begin
          play_position <= '0;
          read_pointer  <= '0;
          loop_forever  <= repeat_req;
          play_mode     <= MODE_PLAY;
        end
      end
      if (cmd.stop && play_mode == MODE_PLAY) begin
        play_mode <= MODE_STOPPING;
      end
      if (cmd.add) begin
        event_count <= event_count + CNT_W'(1);
      end
      if (cmd.step) begin
        read_pointer <= rp_inc;
      end
      // End of a tick: stopping goes idle, playing advances and maybe wraps.
      if (cmd.finish) begin
        unique case (play_mode)
          MODE_STOPPING: play_mode <= MODE_IDLE;
          MODE_PLAY: begin
            if (wrap) begin
              play_position <= '0;
              read_pointer  <= '0;
              if (!loop_forever) begin
                play_mode <= MODE_IDLE;
              end
            end else begin
              play_position <= pos_sum[POS_W-1:0];
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Tick frame offset.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tick_offset <= frame_offset;
    end
  end

  // Data bytes beyond the event size read as zero.
  always_comb begin
    masked_ev = rd_ev;
    if (rd_ev.size < 2'd2) begin
      masked_ev.data1 = 8'd0;
    end
    if (rd_ev.size < 2'd3) begin
      masked_ev.data2 = 8'd0;
    end
  end

  // Pending event, held until the next emission or the end of the tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.take) begin
      pend_valid <= 1'b1;
    end else if (cmd.out_pend) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pend_ev <= masked_ev;
    end
  end

  // Output register.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_pend || cmd.out_reject) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_pend) begin
      result_kind      <= 1'b0;
      out_frame_offset <= tick_offset;
      out_status       <= pend_ev.status;
      out_data1        <= pend_ev.data1;
      out_data2        <= pend_ev.data2;
      out_size         <= pend_ev.size;
      last             <= cmd.out_last;
    end else if (cmd.out_reject) begin
      result_kind      <= 1'b1;
      out_frame_offset <= '0;
      out_status       <= 8'd0;
      out_data1        <= 8'd0;
      out_data2        <= 8'd0;
      out_size         <= 2'd0;
      last             <= 1'b1;
    end
  end

  // Status to the controller.
  always_comb begin
    sts.mode        = play_mode;
    sts.rp_lt_count = read_pointer < event_count;
    sts.more        = rp_inc < event_count;
    sts.due         = {rd_ev.time_f, {FRAC_W{1'b0}}} <= play_position;
    sts.note_off    = (rd_ev.status & STATUS_MASK) == NOTE_OFF_STATUS;
    sts.full        = event_count >= CNT_W'(EVENT_DEPTH);
    sts.pend_valid  = pend_valid;
    sts.out_free    = out_free;
  end

endmodule

`default_nettype wire

// ===== rtl/core/midi_loop_playback_sequencer_unit.sv =====
// Channel    Handshake            Payload
// in         in_valid / in_stall  command, frame_offset, repeat_req, event_*
// out        out_valid / out_stall result_kind, out_frame_offset, out_status..last
// cfg        cfg_valid / cfg_ready cfg_index, cfg_data
//
// Start, stop, clear, a stored add and a tick while idle leave the controller idle; a
// rejected add waits in ST_REJECT for a free output. A playing or stopping tick walks
// the stored events from the read pointer one at a time, set by the single read port of
// the event store, and then ends in ST_FINISH.
// Reset is synchronous; the event store is not cleared, the fill count empties it.
// A stalled output holds the walk until the waiting result is taken.
// Top level; depends on mlps_pkg, mlps_ctrl and mlps_dp.
`default_nettype none

module midi_loop_playback_sequencer_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mlps_pkg::CMD_W-1:0]      command,
  input  logic [mlps_pkg::OFFSET_W-1:0]   frame_offset,
  input  logic                            repeat_req,
  input  logic [mlps_pkg::TIME_W-1:0]     event_time,
  input  logic [7:0]                      event_status,
  input  logic [7:0]                      event_data1,
  input  logic [7:0]                      event_data2,
  input  logic [1:0]                      event_size,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            result_kind,
  output logic [mlps_pkg::OFFSET_W-1:0]   out_frame_offset,
  output logic [7:0]                      out_status,
  output logic [7:0]                      out_data1,
  output logic [7:0]                      out_data2,
  output logic [1:0]                      out_size,
  output logic                            last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mlps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlps_pkg::TIME_W-1:0]     cfg_data
);
  import mlps_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_write;

  // Registers are always writable.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  mlps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .sts      (sts),
    .cmd      (cmd)
  );

  mlps_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .frame_offset     (frame_offset),
    .repeat_req       (repeat_req),
    .event_time       (event_time),
    .event_status     (event_status),
    .event_data1      (event_data1),
    .event_data2      (event_data2),
    .event_size       (event_size),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_kind      (result_kind),
    .out_frame_offset (out_frame_offset),
    .out_status       (out_status),
    .out_data1        (out_data1),
    .out_data2        (out_data2),
    .out_size         (out_size),
    .last             (last)
  );

`ifndef NO_ASSERTIONS
  // No event is left pending once the controller takes new items.
  a_no_pending_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !sts.pend_valid)
    else $error("pending event left behind at end of item");

  // A result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_pend || cmd.out_reject) |-> sts.out_free)
    else $error("output register overwritten");

  // A tick while idle finishes at once.
  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && command == CMD_TICK && sts.mode == MODE_IDLE) |=> !in_stall)
    else $error("idle tick did not finish at once");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_midi_loop_playback_sequencer_unit.sv =====
// Self-checking bench for the MIDI loop playback sequencer: directed rows, then random phases.
// Results are checked in order against a cycle-free model of the sequencer kept in this file.
// Depends on mlps_pkg and midi_loop_playback_sequencer_unit.
`default_nettype none

module tb_midi_loop_playback_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mlps_pkg::*;

  localparam int IDLE_PCT      = 9;
  localparam int RANDOM_ITEMS  = 300;
  localparam int SETTLE_CYCLES = 2 * EVENT_DEPTH + 8;
  localparam int FILL_PHASE    = 2;
  localparam int QUIET_PHASE   = 4;
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  // One command item as it goes onto the input channel.
  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [OFFSET_W-1:0] off;
    logic                rep;
    logic [TIME_W-1:0]   etime;
    logic [7:0]          status;
    logic [7:0]          d1;
    logic [7:0]          d2;
    logic [1:0]          size;
  } seq_cmd_t;

  // One result item as it leaves the output channel.
  typedef struct {
    logic                kind;
    logic [OFFSET_W-1:0] off;
    logic [7:0]          status;
    logic [7:0]          d1;
    logic [7:0]          d2;
    logic [1:0]          size;
    logic                last;
  } midi_out_t;

  typedef enum {ROW_ITEM, ROW_REGS} row_kind_t;

  // A row of the directed table: either one item or a register update.
  // n_typed is -1 when the model supplies the expected results.
  typedef struct {
    row_kind_t         kind;
    seq_cmd_t          it;
    int                n_typed;
    midi_out_t         typed;
    logic              set_len;
    logic [TIME_W-1:0] len;
    logic              set_tempo;
    logic [TIME_W-1:0] tempo;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] command = '0;
  logic [OFFSET_W-1:0] frame_offset = '0;
  logic repeat_req = 1'b0;
  logic [TIME_W-1:0] event_time = '0;
  logic [7:0] event_status = '0;
  logic [7:0] event_data1 = '0;
  logic [7:0] event_data2 = '0;
  logic [1:0] event_size = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic result_kind;
  logic [OFFSET_W-1:0] out_frame_offset;
  logic [7:0] out_status;
  logic [7:0] out_data1;
  logic [7:0] out_data2;
  logic [1:0] out_size;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIME_W-1:0] cfg_data = '0;

  logic quiet = 1'b0;
  int errors = 0;

  // Sequencer model state.
  event_t            ev_mem [EVENT_DEPTH];
  int                ev_fill = 0;
  int                walk_ptr = 0;
  logic [63:0]       play_pos = '0;
  mode_t             pb_mode = MODE_IDLE;
  logic              loop_on = 1'b0;
  logic [TIME_W-1:0] loop_frames = '0;
  logic [TIME_W-1:0] tempo_inc = TEMPO_RESET;

  midi_out_t burst_q[$];
  midi_out_t midi_out_q[$];
  midi_out_t want;
  dir_row_t  rows[$];

  midi_loop_playback_sequencer_unit dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .command          (command),
    .frame_offset     (frame_offset),
    .repeat_req       (repeat_req),
    .event_time       (event_time),
    .event_status     (event_status),
    .event_data1      (event_data1),
    .event_data2      (event_data2),
    .event_size       (event_size),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_kind      (result_kind),
    .out_frame_offset (out_frame_offset),
    .out_status       (out_status),
    .out_data1        (out_data1),
    .out_data2        (out_data2),
    .out_size         (out_size),
    .last             (last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // Queue helpers: append at the tail.
  function automatic void add_burst(midi_out_t r);
    burst_q.insert(burst_q.size(), r);
  endfunction

  function automatic void add_expect(midi_out_t r);
    midi_out_q.insert(midi_out_q.size(), r);
  endfunction

  function automatic void add_row(dir_row_t r);
    rows.insert(rows.size(), r);
  endfunction

  // Turn a stored event into the result a tick reports; bytes past the size read as zero.
  function automatic midi_out_t emit_event(event_t e, logic [OFFSET_W-1:0] off);
    midi_out_t r;
    r.kind   = 1'b0;
    r.off    = off;
    r.status = e.status;
    r.d1     = (e.size >= 2'd2) ? e.data1 : 8'h00;
    r.d2     = (e.size == 2'd3) ? e.data2 : 8'h00;
    r.size   = e.size;
    r.last   = 1'b0;
    return r;
  endfunction

  // Advance the sequencer model by one accepted item and collect its results in burst_q.
  function automatic void sequence_step(seq_cmd_t it);
    midi_out_t rej;
    burst_q.delete();
    case (it.cmd)
      CMD_TICK: begin
        if (pb_mode == MODE_STOPPING) begin
          // Flush only the note-off events left in this pass.
          while (walk_ptr < ev_fill) begin
            if ((ev_mem[walk_ptr].status & STATUS_MASK) == NOTE_OFF_STATUS)
              add_burst(emit_event(ev_mem[walk_ptr], it.off));
            walk_ptr++;
          end
          pb_mode = MODE_IDLE;
        end else if (pb_mode == MODE_PLAY) begin
          while (walk_ptr < ev_fill) begin
            if ({24'h0, ev_mem[walk_ptr].time_f, 16'h0} > play_pos)
              break;
            add_burst(emit_event(ev_mem[walk_ptr], it.off));
            walk_ptr++;
          end
          play_pos += {40'h0, tempo_inc};
          // The wrap test uses the length in force now, so a zero length wraps every tick.
          if (play_pos >= {24'h0, loop_frames, 16'h0}) begin
            if (!loop_on)
              pb_mode = MODE_IDLE;
            play_pos = '0;
            walk_ptr = 0;
          end
        end
      end
      CMD_START: begin
        if (pb_mode == MODE_PLAY) begin
          loop_on = it.rep;
        end else if (pb_mode == MODE_IDLE && loop_frames != '0) begin
          play_pos = '0;
          walk_ptr = 0;
          loop_on  = it.rep;
          pb_mode  = MODE_PLAY;
        end
      end
      CMD_STOP: begin
        if (pb_mode == MODE_PLAY)
          pb_mode = MODE_STOPPING;
      end
      CMD_ADD: begin
        if (ev_fill < EVENT_DEPTH) begin
          ev_mem[ev_fill] = '{it.etime, it.status, it.d1, it.d2, it.size};
          ev_fill++;
        end else begin
          rej = '{1'b1, '0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0};
          add_burst(rej);
        end
      end
      CMD_CLEAR: begin
        if (pb_mode == MODE_IDLE) begin
          loop_frames = '0;
          play_pos    = '0;
          walk_ptr    = 0;
          ev_fill     = 0;
        end
      end
      default: ;
    endcase
    if (burst_q.size() != 0)
      burst_q[burst_q.size() - 1].last = 1'b1;
  endfunction

  // Directed table builders.
  function automatic dir_row_t dir_cmd(logic [CMD_W-1:0] cmd, logic [OFFSET_W-1:0] off,
                                       logic rep, int n_typed);
    dir_row_t r;
    r.kind      = ROW_ITEM;
    r.it.cmd    = cmd;
    r.it.off    = off;
    r.it.rep    = rep;
    r.it.etime  = '0;
    r.it.status = '0;
    r.it.d1     = '0;
    r.it.d2     = '0;
    r.it.size   = '0;
    r.n_typed   = n_typed;
    r.set_len   = 1'b0;
    r.set_tempo = 1'b0;
    return r;
  endfunction

  function automatic dir_row_t dir_add(logic [TIME_W-1:0] t, logic [7:0] st, logic [7:0] d1,
                                       logic [7:0] d2, logic [1:0] sz);
    dir_row_t r;
    r = dir_cmd(CMD_ADD, '0, 1'b0, 0);
    r.it.etime  = t;
    r.it.status = st;
    r.it.d1     = d1;
    r.it.d2     = d2;
    r.it.size   = sz;
    return r;
  endfunction

  function automatic dir_row_t dir_regs(logic set_len, logic [TIME_W-1:0] len,
                                        logic set_tempo, logic [TIME_W-1:0] tempo);
    dir_row_t r;
    r = dir_cmd(CMD_TICK, '0, 1'b0, 0);
    r.kind      = ROW_REGS;
    r.set_len   = set_len;
    r.len       = len;
    r.set_tempo = set_tempo;
    r.tempo     = tempo;
    return r;
  endfunction

  function automatic dir_row_t with_res(dir_row_t r, midi_out_t e);
    r.n_typed = 1;
    r.typed   = e;
    return r;
  endfunction

  // A lone emitted event, which is then also the last result of its tick.
  function automatic midi_out_t ev_res(logic [OFFSET_W-1:0] off, logic [7:0] st,
                                       logic [7:0] d1, logic [7:0] d2, logic [1:0] sz);
    return '{1'b0, off, st, d1, d2, sz, 1'b1};
  endfunction

  // Random item: mostly ticks and adds with times near the play position, some noise.
  function automatic seq_cmd_t rand_item();
    seq_cmd_t it;
    int r;
    r = $urandom_range(99);
    if (r < 50)
      it.cmd = CMD_TICK;
    else if (r < 68)
      it.cmd = CMD_ADD;
    else if (r < 80)
      it.cmd = CMD_START;
    else if (r < 88)
      it.cmd = CMD_STOP;
    else if (r < 92)
      it.cmd = CMD_CLEAR;
    else if (r < 95)
      it.cmd = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
    else
      it.cmd = CMD_TICK;
    it.off   = OFFSET_W'($urandom);
    it.rep   = ($urandom_range(99) < 75);
    it.etime = ($urandom_range(99) < 80) ? TIME_W'($urandom_range(40, 0)) : TIME_W'($urandom);
    it.status = 8'($urandom);
    if ($urandom_range(99) < 40)
      it.status[7:4] = NOTE_OFF_STATUS[7:4];
    it.d1   = 8'($urandom);
    it.d2   = 8'($urandom);
    it.size = 2'($urandom);
    return it;
  endfunction

  function automatic logic [TIME_W-1:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 8)
      return '0;
    else if (r < 16)
      return '1;
    else if (r < 26)
      return TIME_W'($urandom);
    return TIME_W'($urandom_range(24, 1));
  endfunction

  function automatic logic [TIME_W-1:0] pick_tempo();
    int r;
    r = $urandom_range(99);
    if (r < 8)
      return '0;
    else if (r < 16)
      return '1;
    else if (r < 26)
      return TIME_W'($urandom);
    return TIME_W'($urandom_range(24'h30000, 24'h2000));
  endfunction

  // Offer one item, hold it until taken, then record what it should produce.
  task automatic play_item(seq_cmd_t it, int n_typed, midi_out_t typed);
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 50);
    end
    in_valid     <= 1'b1;
    command      <= it.cmd;
    frame_offset <= it.off;
    repeat_req   <= it.rep;
    event_time   <= it.etime;
    event_status <= it.status;
    event_data1  <= it.d1;
    event_data2  <= it.d2;
    event_size   <= it.size;
    do @(posedge clk); while (in_stall);
    sequence_step(it);
    if (n_typed < 0) begin
      foreach (burst_q[i])
        add_expect(burst_q[i]);
    end else if (n_typed > 0) begin
      add_expect(typed);
    end
  endtask

  // Drop valid, then wait on the clock until every expected result is in.
  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (midi_out_q.size() != 0);
  endtask

  // Let a tick that emits nothing finish its walk before touching registers.
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic set_len, logic [TIME_W-1:0] len,
                            logic set_tempo, logic [TIME_W-1:0] tempo);
    if (set_len) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_LOOP_LENGTH;
      cfg_data  <= len;
      do @(posedge clk); while (!cfg_ready);
      loop_frames = len;
    end
    if (set_tempo) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_TEMPO_STEP;
      cfg_data  <= tempo;
      do @(posedge clk); while (!cfg_ready);
      tempo_inc = tempo;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0d ns: %s expected %0h, got %0h", $time, name, exp_v, got_v);
    end
  endtask

  // Output side: check each taken result against the oldest expectation, stall at random.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (midi_out_q.size() == 0) begin
          errors++;
          $display("%0d ns: result expected none, got status %0h", $time, out_status);
        end else begin
          want = midi_out_q.pop_front();
          check_field("result_kind", 32'(want.kind), 32'(result_kind));
          check_field("out_frame_offset", 32'(want.off), 32'(out_frame_offset));
          check_field("out_status", 32'(want.status), 32'(out_status));
          check_field("out_data1", 32'(want.d1), 32'(out_data1));
          check_field("out_data2", 32'(want.d2), 32'(out_data2));
          check_field("out_size", 32'(want.size), 32'(out_size));
          check_field("last", 32'(want.last), 32'(last));
        end
      end
      out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Stimulus: directed table, then random phases with register changes between them.
  initial begin
    seq_cmd_t  it;
    midi_out_t none_res;
    int        sent;
    int        ph;
    int        n;

    none_res = '{1'b0, '0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0};

    // Idle machine with reset registers: nothing may come out.
    add_row(dir_cmd(CMD_TICK, 13'h1FFF, 1'b0, 0));
    add_row(dir_cmd(CMD_START, '0, 1'b1, 0));
    add_row(dir_cmd(CMD_STOP, '0, 1'b0, 0));
    add_row(dir_cmd(CMD_SPARE_FIRST, '0, 1'b0, 0));
    // Store: time extremes, note-off status, a zero-size event, and full byte values.
    add_row(dir_add(24'h000000, 8'h90, 8'h3C, 8'h7F, 2'd3));
    add_row(dir_add(24'hFFFFFF, 8'h80, 8'hFF, 8'hFF, 2'd2));
    add_row(dir_add(24'h000001, 8'h85, 8'hAA, 8'h55, 2'd0));
    add_row(dir_add(24'h000002, 8'hFF, 8'hFF, 8'hFF, 2'd1));
    // Play a three-frame loop, restart while playing, and try clear while busy.
    add_row(dir_regs(1'b1, 24'd3, 1'b0, '0));
    add_row(dir_cmd(CMD_START, '0, 1'b0, 0));
    add_row(dir_cmd(CMD_START, '0, 1'b1, 0));
    add_row(with_res(dir_cmd(CMD_TICK, '0, 1'b0, 0),
                     ev_res('0, 8'h90, 8'h3C, 8'h7F, 2'd3)));
    add_row(dir_cmd(CMD_TICK, 13'h1FFF, 1'b0, 0));
    add_row(dir_cmd(CMD_CLEAR, '0, 1'b0, 0));
    // Stop, ignored start, then the note-off flush.
    add_row(dir_cmd(CMD_STOP, '0, 1'b0, 0));
    add_row(dir_cmd(CMD_START, '0, 1'b1, 0));
    add_row(dir_cmd(CMD_TICK, 13'h1555, 1'b0, -1));
    add_row(dir_cmd(CMD_TICK, '0, 1'b0, 0));
    // Largest tempo: one tick plays the due event and wraps straight to idle.
    add_row(dir_regs(1'b0, '0, 1'b1, 24'hFFFFFF));
    add_row(dir_cmd(CMD_START, '0, 1'b0, 0));
    add_row(with_res(dir_cmd(CMD_TICK, 13'h0AAA, 1'b0, 0),
                     ev_res(13'h0AAA, 8'h90, 8'h3C, 8'h7F, 2'd3)));
    add_row(dir_cmd(CMD_CLEAR, '0, 1'b0, 0));
    // Longest loop with zero tempo: the position never moves.
    add_row(dir_regs(1'b1, 24'hFFFFFF, 1'b1, 24'h000000));
    add_row(dir_add(24'h000000, 8'h8F, 8'h12, 8'h34, 2'd3));
    add_row(dir_cmd(CMD_START, '0, 1'b1, 0));
    add_row(with_res(dir_cmd(CMD_TICK, 13'h0F0F, 1'b0, 0),
                     ev_res(13'h0F0F, 8'h8F, 8'h12, 8'h34, 2'd3)));
    add_row(dir_cmd(CMD_TICK, '0, 1'b0, 0));
    add_row(dir_cmd(CMD_STOP, '0, 1'b0, 0));
    add_row(dir_cmd(CMD_TICK, '0, 1'b0, 0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REGS) begin
        settle();
        write_regs(rows[i].set_len, rows[i].len, rows[i].set_tempo, rows[i].tempo);
      end else begin
        play_item(rows[i].it, rows[i].n_typed, rows[i].typed);
      end
    end

    sent = 0;
    ph   = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      quiet <= (ph == QUIET_PHASE);
      if (ph == FILL_PHASE) begin
        // Bring the machine to idle, empty the store, then overfill it with early events.
        it = rand_item();
        it.cmd = CMD_STOP;
        play_item(it, -1, none_res);
        it.cmd = CMD_TICK;
        play_item(it, -1, none_res);
        it.cmd = CMD_CLEAR;
        play_item(it, -1, none_res);
        settle();
        write_regs(1'b1, 24'd40, 1'b1, 24'h010000);
        repeat (EVENT_DEPTH + 2) begin
          it = rand_item();
          it.cmd   = CMD_ADD;
          it.etime = TIME_W'($urandom_range(3, 0));
          play_item(it, -1, none_res);
        end
        it.cmd = CMD_START;
        it.rep = 1'b1;
        play_item(it, -1, none_res);
        repeat (4) begin
          it = rand_item();
          it.cmd = CMD_TICK;
          play_item(it, -1, none_res);
        end
        sent += EVENT_DEPTH + 9;
        settle();
      end
      write_regs($urandom_range(99) < 80, pick_len(), $urandom_range(99) < 60, pick_tempo());
      n = (ph == QUIET_PHASE) ? 40 : $urandom_range(20, 8);
      repeat (n) begin
        // Now and then hold the next item back until every result is in.
        if ($urandom_range(99) < 3)
          wait_results();
        it = rand_item();
        play_item(it, -1, none_res);
        if (it.cmd <= CMD_CLEAR)
          sent++;
      end
      ph++;
    end

    settle();
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
